// File: src/affine_transform_matrix_engine_unit_macros.svh
// assertion macros shared by the transform engine modules
// expects i_clk and i_rst_n in the module that uses them
`ifndef AFFINE_TRANSFORM_MATRIX_ENGINE_UNIT_MACROS_SVH
`define AFFINE_TRANSFORM_MATRIX_ENGINE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ATME_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("transform engine check failed");
`define ATME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error("transform engine sequence check failed");
`else
`define ATME_ASSERT(lbl, prop)
`define ATME_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/atme_pkg.sv
// types and constants of the 4x4 transform engine
// used by the controller, the datapath and the top level
package atme_pkg;

    typedef enum logic [2:0] {
        OP_IDENTITY  = 3'd0,
        OP_WR_CUR    = 3'd1,
        OP_WR_OPD    = 3'd2,
        OP_COMPOSE   = 3'd3,
        OP_TRANSLATE = 3'd4,
        OP_OFFSET    = 3'd5,
        OP_TRANSFORM = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       issue;
        logic [1:0] row;
        logic [1:0] col;
    } t_dp_cmd;

    // status back to the controller
    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

    localparam int unsigned ENTRY_W = 32;
    localparam int unsigned PROD_W  = 2 * ENTRY_W;
    localparam int unsigned SUM_W   = PROD_W + 2;
    localparam logic [1:0]  LAST_COL = 2'd3;

endpackage

// File: src/atme_ctrl.sv
// controller state machine of the transform engine
// depends on atme_pkg and the assertion macro header
`include "affine_transform_matrix_engine_unit_macros.svh"

module atme_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  atme_pkg::t_op        i_op,
    input  atme_pkg::t_dp_status i_status,
    output atme_pkg::t_dp_cmd    o_cmd,
    output logic                 busy,
    output logic                 o_strobe
);
    import atme_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    t_op        r_op, n_op;
    logic       last_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_op    <= OP_IDENTITY;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        o_cmd      = '0;
        busy       = 1'b1;
        o_strobe   = 1'b0;
        last_issue = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_op;
                    n_cnt      = '0;
                    if (i_op == OP_COMPOSE || i_op == OP_TRANSLATE
                        || i_op == OP_TRANSFORM) begin
                        n_state = ST_ISSUE;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_DONE;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (r_op == OP_COMPOSE) begin
                    o_cmd.row  = r_cnt[3:2];
                    o_cmd.col  = r_cnt[1:0];
                    last_issue = (r_cnt == 4'd15);
                end else begin
                    o_cmd.row  = r_cnt[1:0];
                    o_cmd.col  = LAST_COL;
                    last_issue = (r_op == OP_TRANSLATE) ? (r_cnt == 4'd3) : (r_cnt == 4'd2);
                end
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ATME_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ATME_ASSERT_NEXT(a_strobe_idle, o_strobe, !busy)
    `ATME_ASSERT(a_strobe_after_work, o_strobe |-> $past(busy))
    `ATME_ASSERT(a_issue_not_idle, o_cmd.issue |-> busy && !o_strobe)

endmodule

// File: src/atme_datapath.sv
// matrix storage, four multipliers and the accumulate/saturate pipeline
// depends on atme_pkg and the assertion macro header
`include "affine_transform_matrix_engine_unit_macros.svh"

module atme_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atme_pkg::t_dp_cmd    i_cmd,
    input  atme_pkg::t_op        i_op,
    input  logic [1:0]           i_row,
    input  logic [1:0]           i_col,
    input  logic signed [31:0]   i_value,
    input  logic signed [31:0]   i_x_coord,
    input  logic signed [31:0]   i_y_coord,
    input  logic signed [31:0]   i_z_coord,
    output atme_pkg::t_dp_status o_status,
    output logic signed [31:0]   o_out_x,
    output logic signed [31:0]   o_out_y,
    output logic signed [31:0]   o_out_z,
    output logic                 o_saturated
);
    import atme_pkg::*;

    localparam logic signed [ENTRY_W-1:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ENTRY_W-1:0] E_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [ENTRY_W-1:0] E_MIN   = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0]   SUM_MAX = SUM_W'(E_MAX);
    localparam logic signed [SUM_W-1:0]   SUM_MIN = SUM_W'(E_MIN);

    logic signed [ENTRY_W-1:0] r_cur [4][4];
    logic signed [ENTRY_W-1:0] r_opd [4][4];
    logic signed [ENTRY_W-1:0] r_rb  [3];

    t_op                       r_op;
    logic [1:0]                r_row, r_col;
    logic signed [ENTRY_W-1:0] r_value;
    logic signed [ENTRY_W-1:0] r_vec [3];
    logic signed [ENTRY_W-1:0] r_out [3];
    logic                      r_sat;

    // pipeline: products, then sum, then shift/saturate/writeback
    logic                      r_v1, r_v2;
    logic [1:0]                r_row1, r_col1, r_row2, r_col2;
    logic signed [PROD_W-1:0]  r_prod [4];
    logic signed [SUM_W-1:0]   r_sum;

    logic signed [ENTRY_W-1:0] opa [4];
    logic signed [ENTRY_W-1:0] opb [4];
    logic signed [SUM_W-1:0]   shifted;
    logic signed [ENTRY_W-1:0] wb_val;
    logic                      wb_sat;
    logic signed [ENTRY_W:0]   off_sum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            opa[k] = r_cur[i_cmd.row][k];
            opb[k] = (r_op == OP_COMPOSE) ? r_opd[k][i_cmd.col] : r_vec[k];
        end
        // homogeneous coordinate of the point or translation column
        opa[3] = r_cur[i_cmd.row][3];
        opb[3] = (r_op == OP_COMPOSE) ? r_opd[3][i_cmd.col] : ONE_Q;
    end

    always_comb begin
        shifted = r_sum >>> FRAC_BITS;
        wb_sat  = 1'b0;
        if (shifted > SUM_MAX) begin
            wb_val = E_MAX;
            wb_sat = 1'b1;
        end else if (shifted < SUM_MIN) begin
            wb_val = E_MIN;
            wb_sat = 1'b1;
        end else begin
            wb_val = shifted[ENTRY_W-1:0];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            off_sum[r] = (ENTRY_W+1)'(r_cur[r][3]) + (ENTRY_W+1)'(r_vec[r]);
        end
    end

    // multiplier and adder stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= PROD_W'(opa[k]) * PROD_W'(opb[k]);
        end
        r_row1 <= i_cmd.row;
        r_col1 <= i_cmd.col;
        r_row2 <= r_row1;
        r_col2 <= r_col1;
        r_sum  <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
                + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
    end

    // item latch, matrix updates and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_cur[r][c] <= (r == c) ? ONE_Q : '0;
                    r_opd[r][c] <= '0;
                end
            end
            r_op  <= OP_IDENTITY;
            r_sat <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_out[r] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_op     <= i_op;
                r_row    <= i_row;
                r_col    <= i_col;
                r_value  <= i_value;
                r_vec[0] <= i_x_coord;
                r_vec[1] <= i_y_coord;
                r_vec[2] <= i_z_coord;
                r_sat    <= 1'b0;
                for (int r = 0; r < 3; r++) begin
                    r_out[r] <= '0;
                end
            end
            if (i_cmd.exec) begin
                unique case (r_op)
                    OP_IDENTITY: begin
                        for (int r = 0; r < 4; r++) begin
                            for (int c = 0; c < 4; c++) begin
                                r_cur[r][c] <= (r == c) ? ONE_Q : '0;
                            end
                        end
                    end
                    OP_WR_CUR: r_cur[r_row][r_col] <= r_value;
                    OP_WR_OPD: r_opd[r_row][r_col] <= r_value;
                    OP_OFFSET: begin
                        for (int r = 0; r < 3; r++) begin
                            if (off_sum[r][ENTRY_W] != off_sum[r][ENTRY_W-1]) begin
                                r_cur[r][3] <= off_sum[r][ENTRY_W] ? E_MIN : E_MAX;
                                r_sat       <= 1'b1;
                            end else begin
                                r_cur[r][3] <= off_sum[r][ENTRY_W-1:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (r_v2) begin
                if (wb_sat) begin
                    r_sat <= 1'b1;
                end
                if (r_op == OP_COMPOSE) begin
                    // row is committed whole once its last column is done
                    if (r_col2 != LAST_COL) begin
                        r_rb[r_col2] <= wb_val;
                    end else begin
                        r_cur[r_row2][0] <= r_rb[0];
                        r_cur[r_row2][1] <= r_rb[1];
                        r_cur[r_row2][2] <= r_rb[2];
                        r_cur[r_row2][3] <= wb_val;
                    end
                end else if (r_op == OP_TRANSLATE) begin
                    r_cur[r_row2][3] <= wb_val;
                end else if (r_row2 != LAST_COL) begin
                    r_out[r_row2] <= wb_val;
                end
            end
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2 | i_cmd.issue;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_saturated = r_sat;

    `ATME_ASSERT_NEXT(a_load_clears, i_cmd.load, !r_sat && r_out[0] == '0)
    `ATME_ASSERT(a_no_exec_in_pipe, i_cmd.exec |-> !r_v1 && !r_v2 && !i_cmd.issue)

endmodule

// File: src/affine_transform_matrix_engine_unit.sv
// top level of the 4x4 homogeneous transform engine
// depends on atme_pkg, atme_ctrl and atme_datapath
//
// usage
//  - one command transfer is taken at a rising edge with start high and busy low;
//    the operation code and the row, col, value and x/y/z coordinates go with it
//  - every command gives exactly one result transfer: o_strobe is high for one
//    cycle with o_out_x/y/z and o_saturated; the receiver cannot hold it off
//  - out_x/y/z are only meaningful for a point transform, zero otherwise
//  - o_saturated reports any clamp of an output or a stored entry by that command
// timing
//  - identity, entry writes, column offset and the undefined code: an execute state,
//    then the strobe state
//  - transform: 3 dot products, compose: 16, translation: 4, one per cycle on
//    four shared 32x32 multipliers, then sum, shift/saturate, an empty-pipe
//    check and the strobe cycle
//  - busy stays high from the accepting edge to the end of the strobe cycle,
//    so one command is in flight at a time
// reset
//  - synchronous, active low; current matrix back to identity, operand matrix
//    cleared, no result pending

module affine_transform_matrix_engine_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    output logic               o_strobe,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_saturated
);
    import atme_pkg::*;

    // command and status between the sequencer and the arithmetic
    t_dp_cmd    cmd;
    t_dp_status status;
    t_op        op;

    // undefined code passes through the enum unchanged and does nothing
    assign op = t_op'(i_operation);

    atme_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (op),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    atme_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_z_coord   (i_z_coord),
        .o_status    (status),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_saturated (o_saturated)
    );

endmodule

// File: tb/sv/affine_transform_matrix_engine_unit_tb.sv
// self-checking testbench of the 4x4 homogeneous transform engine
// holds its own matrix model and compares every result transfer with it
// depends on atme_pkg and affine_transform_matrix_engine_unit
`timescale 1ns / 1ps

module affine_transform_matrix_engine_unit_tb;
    import atme_pkg::*;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;
    localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
    localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;
    // the one code the package leaves unnamed: the engine must ignore it
    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam int RANDOM_TARGET = 1225;
    localparam int TAIL_CYCLES = 25;

    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 drain_first;
    } engine_cmd_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               clamped;
    } engine_point_t;

    // dut ports, all inputs known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_operation = '0;
    logic [1:0]         i_row = '0;
    logic [1:0]         i_col = '0;
    logic signed [31:0] i_value = '0;
    logic signed [31:0] i_x_coord = '0;
    logic signed [31:0] i_y_coord = '0;
    logic signed [31:0] i_z_coord = '0;
    logic               o_strobe;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic               o_saturated;

    // model state: both matrices row-major, plus scratch for the right-hand side
    logic signed [31:0] cur_m [16];
    logic signed [31:0] opd_m [16];
    logic signed [31:0] rhs_m [16];

    engine_cmd_t   pending_cmds[$];
    engine_point_t expected_points[$];

    bit took_cmd = 1'b0;
    bit drain_next = 1'b0;
    int idle_left = 0;
    int no_idle_left = 0;
    int error_count = 0;
    int results_checked = 0;
    int clamp_results = 0;
    int op_seen [8];

    affine_transform_matrix_engine_unit #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_z_coord   (i_z_coord),
        .o_strobe    (o_strobe),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_saturated (o_saturated)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // clamp a wide signed value into q16.16 range and flag the clamp
    function automatic logic signed [31:0] clamp_q(input logic signed [65:0] v,
                                                   inout bit clamped);
        if (v > WIDE_MAX) begin
            clamped = 1'b1;
            return MAX_Q;
        end
        if (v < WIDE_MIN) begin
            clamped = 1'b1;
            return MIN_Q;
        end
        return v[31:0];
    endfunction

    // exact sum of four full products, floor shift, then clamp
    function automatic logic signed [31:0] dot_q(
        input logic signed [31:0] a0, a1, a2, a3,
        input logic signed [31:0] b0, b1, b2, b3,
        inout bit clamped
    );
        logic signed [65:0] acc;
        acc = a0 * b0 + a1 * b1 + a2 * b2 + a3 * b3;
        acc = acc >>> FRAC;
        return clamp_q(acc, clamped);
    endfunction

    // apply one accepted command to the matrices and work out its result
    task automatic apply_to_matrices(input engine_cmd_t c, output engine_point_t r);
        logic signed [31:0] mat_new [16];
        logic signed [31:0] pt [4];
        logic signed [65:0] wide;
        bit clamped;
        int rr;
        int cc;
        clamped = 1'b0;
        r = '0;
        pt[0] = c.x;
        pt[1] = c.y;
        pt[2] = c.z;
        pt[3] = ONE_Q;
        case (c.op)
            OP_IDENTITY: begin
                for (rr = 0; rr < 16; rr++)
                    cur_m[rr] = (rr % 5 == 0) ? ONE_Q : '0;
            end
            OP_WR_CUR: cur_m[{c.row, c.col}] = c.value;
            OP_WR_OPD: opd_m[{c.row, c.col}] = c.value;
            OP_COMPOSE: begin
                rhs_m = opd_m;
            end
            OP_TRANSLATE: begin
                // identity with the translation in column 3
                for (rr = 0; rr < 16; rr++)
                    rhs_m[rr] = (rr % 5 == 0) ? ONE_Q : '0;
                rhs_m[3]  = c.x;
                rhs_m[7]  = c.y;
                rhs_m[11] = c.z;
            end
            OP_OFFSET: begin
                for (rr = 0; rr < 3; rr++) begin
                    wide = cur_m[rr * 4 + 3] + pt[rr];
                    cur_m[rr * 4 + 3] = clamp_q(wide, clamped);
                end
            end
            OP_TRANSFORM: begin
                r.x = dot_q(cur_m[0], cur_m[1], cur_m[2], cur_m[3],
                            pt[0], pt[1], pt[2], pt[3], clamped);
                r.y = dot_q(cur_m[4], cur_m[5], cur_m[6], cur_m[7],
                            pt[0], pt[1], pt[2], pt[3], clamped);
                r.z = dot_q(cur_m[8], cur_m[9], cur_m[10], cur_m[11],
                            pt[0], pt[1], pt[2], pt[3], clamped);
            end
            default: ;
        endcase
        // compose and translation share the matrix product, all from the old matrix
        if (c.op == OP_COMPOSE || c.op == OP_TRANSLATE) begin
            for (rr = 0; rr < 4; rr++)
                for (cc = 0; cc < 4; cc++)
                    mat_new[rr * 4 + cc] = dot_q(
                        cur_m[rr * 4], cur_m[rr * 4 + 1], cur_m[rr * 4 + 2], cur_m[rr * 4 + 3],
                        rhs_m[cc], rhs_m[4 + cc], rhs_m[8 + cc], rhs_m[12 + cc], clamped);
            cur_m = mat_new;
        end
        r.clamped = clamped;
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    task automatic queue_cmd(input logic [2:0] op, input logic [1:0] row, input logic [1:0] col,
                             input logic signed [31:0] value, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
        engine_cmd_t c;
        c.op = op;
        c.row = row;
        c.col = col;
        c.value = value;
        c.x = x;
        c.y = y;
        c.z = z;
        c.drain_first = drain_next;
        drain_next = 1'b0;
        pending_cmds.push_back(c);
    endtask

    // matrix entries: mostly within +-4.0 so products stay in range, some near unity,
    // some across the full 32 bits
    function automatic logic signed [31:0] rand_entry();
        int pick;
        logic signed [31:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            s = $urandom_range(0, 32'h0008_0000);
            return s - 32'sh0004_0000;
        end
        if (pick < 75) begin
            s = $urandom_range(0, 2048);
            return ONE_Q + s - 32'sd1024;
        end
        if (pick < 85)
            return '0;
        return $urandom;
    endfunction

    // coordinates: mostly within +-256.0, the rest full range
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] s;
        if ($urandom_range(0, 9) < 7) begin
            s = $urandom_range(0, 32'h0200_0000);
            return s - 32'sh0100_0000;
        end
        return $urandom;
    endfunction

    // idle gap after a transfer: mostly none or short, a few long, with bursts
    function automatic int pick_idle();
        int pick;
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            no_idle_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // ---------------------------------------------------------------------
    // driver: inputs change on the falling edge only
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin : cmd_driver
        engine_cmd_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took_cmd) begin
            // command still waiting for busy to drop, hold it
        end else if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (pending_cmds.size() == 0) begin
            start <= 1'b0;
        end else if (pending_cmds[0].drain_first && expected_points.size() != 0) begin
            // hold off until every outstanding result transfer has arrived
            start <= 1'b0;
        end else begin
            nxt = pending_cmds.pop_front();
            i_operation <= nxt.op;
            i_row       <= nxt.row;
            i_col       <= nxt.col;
            i_value     <= nxt.value;
            i_x_coord   <= nxt.x;
            i_y_coord   <= nxt.y;
            i_z_coord   <= nxt.z;
            start       <= 1'b1;
            idle_left   <= pick_idle();
        end
    end

    // ---------------------------------------------------------------------
    // monitor: checks result transfers and predicts on each command transfer
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        engine_cmd_t   acc;
        engine_point_t want;
        took_cmd <= i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            if (expected_points.size() == 0) begin
                error_count++;
                $error("result transfer with no command outstanding");
            end else begin
                want = expected_points.pop_front();
                results_checked++;
                if (o_saturated === 1'b1)
                    clamp_results++;
                if (o_out_x !== want.x) begin
                    error_count++;
                    $error("out_x: expected %0d, got %0d", want.x, o_out_x);
                end
                if (o_out_y !== want.y) begin
                    error_count++;
                    $error("out_y: expected %0d, got %0d", want.y, o_out_y);
                end
                if (o_out_z !== want.z) begin
                    error_count++;
                    $error("out_z: expected %0d, got %0d", want.z, o_out_z);
                end
                if (o_saturated !== want.clamped) begin
                    error_count++;
                    $error("saturated: expected %0d, got %0d", want.clamped, o_saturated);
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            acc.op = i_operation;
            acc.row = i_row;
            acc.col = i_col;
            acc.value = i_value;
            acc.x = i_x_coord;
            acc.y = i_y_coord;
            acc.z = i_z_coord;
            acc.drain_first = 1'b0;
            apply_to_matrices(acc, want);
            expected_points.push_back(want);
            op_seen[acc.op]++;
        end
    end

    // ---------------------------------------------------------------------
    // run control
    // ---------------------------------------------------------------------
    initial begin : run_control
        int kind;
        int k;
        int n;
        bit affine;
        for (k = 0; k < 8; k++)
            op_seen[k] = 0;
        for (k = 0; k < 16; k++) begin
            cur_m[k] = (k % 5 == 0) ? ONE_Q : '0;
            opd_m[k] = '0;
            rhs_m[k] = '0;
        end

        // directed: extremes, every code, clamps on outputs and stored entries
        queue_cmd(OP_IDENTITY, 2'd3, 2'd3, MAX_Q, MIN_Q, MAX_Q, MIN_Q);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, MIN_Q, MAX_Q, -32'sd1);
        queue_cmd(OP_WR_CUR, 2'd0, 2'd0, MAX_Q, '0, '0, '0);
        queue_cmd(OP_WR_CUR, 2'd1, 2'd1, MIN_Q, '0, '0, '0);
        queue_cmd(OP_WR_CUR, 2'd3, 2'd3, ONE_Q, -32'sd1, -32'sd1, -32'sd1);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, MAX_Q, MIN_Q, 32'sd1);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, MAX_Q, MAX_Q, '0);
        queue_cmd(OP_OFFSET, 2'd0, 2'd0, '0, MAX_Q, MIN_Q, MAX_Q);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(OP_WR_OPD, 2'd0, 2'd0, MAX_Q, '0, '0, '0);
        queue_cmd(OP_WR_OPD, 2'd3, 2'd3, MIN_Q, '0, '0, '0);
        queue_cmd(OP_WR_OPD, 2'd2, 2'd1, 32'sh0002_0000, '0, '0, '0);
        queue_cmd(OP_COMPOSE, 2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, 32'sh0001_8000, -32'sh0000_8000, ONE_Q);
        queue_cmd(OP_TRANSLATE, 2'd0, 2'd0, '0, MAX_Q, MIN_Q, MAX_Q);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, ONE_Q, ONE_Q, ONE_Q);
        queue_cmd(OP_UNDEFINED, 2'd3, 2'd3, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_cmd(OP_IDENTITY, 2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(OP_TRANSLATE, 2'd0, 2'd0, '0, ONE_Q, -32'sh0002_0000, 32'sh0003_0000);
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
        queue_cmd(OP_WR_OPD, 2'd3, 2'd0, -32'sd1, '0, '0, '0);
        queue_cmd(OP_COMPOSE, 2'd0, 2'd0, '0, '0, '0, '0);
        // negative fractions check the floor rounding
        queue_cmd(OP_TRANSFORM, 2'd0, 2'd0, '0, -32'sd1, -32'sd3, -32'sd7);
        queue_cmd(OP_UNDEFINED, 2'd0, 2'd0, '0, '0, '0, '0);
        drain_next = 1'b1;

        // random: mostly well-formed sequences, some noise and broken loads
        while (pending_cmds.size() < RANDOM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 2)
                drain_next = 1'b1;
            if (kind < 30) begin
                // full operand load, compose, then use it
                affine = $urandom_range(0, 9) < 7;
                for (k = 0; k < 16; k++)
                    queue_cmd(OP_WR_OPD, k[3:2], k[1:0],
                              (affine && k >= 12) ? ((k == 15) ? ONE_Q : '0) : rand_entry(),
                              $urandom, $urandom, $urandom);
                queue_cmd(OP_COMPOSE, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    queue_cmd(OP_TRANSFORM, $urandom, $urandom, $urandom, rand_coord(),
                              rand_coord(), rand_coord());
            end else if (kind < 50) begin
                // fresh identity, chain of translations, transforms
                queue_cmd(OP_IDENTITY, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    queue_cmd(OP_TRANSLATE, $urandom, $urandom, $urandom, rand_coord(),
                              rand_coord(), rand_coord());
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    queue_cmd(OP_TRANSFORM, $urandom, $urandom, $urandom, rand_coord(),
                              rand_coord(), rand_coord());
            end else if (kind < 65) begin
                // direct writes into the current matrix
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    queue_cmd(OP_WR_CUR, $urandom, $urandom, rand_entry(), $urandom,
                              $urandom, $urandom);
                queue_cmd(OP_TRANSFORM, $urandom, $urandom, $urandom, rand_coord(),
                          rand_coord(), rand_coord());
            end else if (kind < 75) begin
                // column offsets
                n = $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    queue_cmd(OP_OFFSET, $urandom, $urandom, $urandom, rand_coord(),
                              rand_coord(), rand_coord());
                queue_cmd(OP_TRANSFORM, $urandom, $urandom, $urandom, rand_coord(),
                          rand_coord(), rand_coord());
            end else if (kind < 88) begin
                // noise: any code, every field at random
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    queue_cmd($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            end else begin
                // partial operand load before a compose
                n = $urandom_range(1, 15);
                for (k = 0; k < n; k++)
                    queue_cmd(OP_WR_OPD, $urandom, $urandom, rand_entry(), $urandom,
                              $urandom, $urandom);
                queue_cmd(OP_COMPOSE, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
                queue_cmd(OP_TRANSFORM, $urandom, $urandom, $urandom, rand_coord(),
                          rand_coord(), rand_coord());
            end
        end

        // reset held from time zero, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every command transfer, then for every result transfer
        while (pending_cmds.size() != 0 || start)
            @(posedge i_clk);
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            error_count++;
            $error("%0d results never arrived", expected_points.size());
        end

        $display("covered %0d commands: identity %0d, current writes %0d, operand writes %0d,",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3] + op_seen[4] + op_seen[5]
                 + op_seen[6] + op_seen[7], op_seen[0], op_seen[1], op_seen[2]);
        $display("compose %0d, translate %0d, offset %0d, transform %0d, undefined %0d; "
                 , op_seen[3], op_seen[4], op_seen[5], op_seen[6], op_seen[7],
                 "%0d results checked, %0d clamped, %0d mismatches",
                 results_checked, clamp_results, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
